// ===== hdl/software_timer_bank_top_defines.svh =====
// assertion macros for the software timer bank
// no dependencies; included by files that carry concurrent checks
`ifndef SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define STB_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define STB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stb_pkg.sv =====
// shared types and constants of the software timer bank
// no dependencies; imported by the arithmetic unit and the top level
`timescale 1ns / 1ps

package stb_pkg;

    // number of timer slots, capped by the 4-bit slot fields
    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = 4;
    localparam int SLOT_SPAN  = 1 << SLOT_W;
    localparam int SLOT_CNT   = (NUM_TIMERS < SLOT_SPAN) ? NUM_TIMERS : SLOT_SPAN;
    localparam int TIME_W     = 32;

    typedef enum logic [1:0] {
        CMD_POLL   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_NO_SLOT   = 2'd2
    } t_status;

    // one command request
    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic              periodic;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] now_ms;
    } t_req;

    // one result
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_out;
        logic              fired;
        logic              last;
    } t_rsp;

    // operands of the shared time arithmetic unit
    typedef struct packed {
        logic [TIME_W-1:0] add_a;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] now;
    } t_alu_op;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              expired;
    } t_alu_res;

endpackage

// ===== hdl/stb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; holds the per-slot period and deadline words
`timescale 1ns / 1ps

module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/stb_alu.sv =====
// shared time arithmetic: deadline sum and wrap-aware expiry compare
// depends on stb_pkg
`timescale 1ns / 1ps

module stb_alu
    import stb_pkg::*;
(
    input  t_alu_op  i_op,
    output t_alu_res o_res
);

    logic [TIME_W-1:0] diff;

    // sum for new deadlines, signed difference now - base for expiry
    always_comb begin
        diff          = i_op.now - i_op.base;
        o_res.sum     = i_op.add_a + i_op.base;
        o_res.expired = ~diff[TIME_W-1];
    end

endmodule

// ===== hdl/software_timer_bank_top.sv =====
// top level of the software timer bank: command sequencer and slot flags
// depends on stb_pkg, stb_ram, stb_alu and software_timer_bank_top_defines.svh
`timescale 1ns / 1ps
`include "software_timer_bank_top_defines.svh"

// Command-driven bank of SLOT_CNT software timers. Create, start and stop
// each pass through the execute state, which registers their result. A poll
// walks the slots one per cycle, unless a second expiry waits, through the
// shared time arithmetic unit, fed by the registered reads of the deadline
// and period rams, then ends in the flush state. A second expiry waits
// while the earlier result cannot leave. The final result of any request
// waits until the output register is free. Every poll gives one result per
// fired slot in ascending slot order, the final one marked last, or a
// single non-fired result when nothing expired. Requests are taken only
// while the block is idle; a finished result may still wait in the output
// register while the next request is accepted.
module software_timer_bank_top
    import stb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [SLOT_SPAN-1:0]  r_alloc, n_alloc;
    logic [SLOT_SPAN-1:0]  r_per_mark, n_per_mark;
    logic [SLOT_SPAN-1:0]  r_run, n_run;
    logic                  r_pend_v, n_pend_v;
    logic [SLOT_W-1:0]     r_pend_slot, n_pend_slot;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  fire;
    logic                  blocked;
    logic                  advance;
    logic                  slot_ok;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  dl_we;
    logic [SLOT_W-1:0]     dl_waddr;
    logic                  per_we;
    logic [TIME_W-1:0]     dl_rd;
    logic [TIME_W-1:0]     per_rd;
    t_alu_op               alu_op;
    t_alu_res              alu_res;

    // request handshake and output register space
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // lowest free slot for create
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOT_CNT - 1; k >= 0; k--) begin
            if (!r_alloc[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    // addressed slot exists and was created
    assign slot_ok = ({1'b0, r_req.slot} < (SLOT_W + 1)'(SLOT_CNT)) && r_alloc[r_req.slot];

    // scan step: a second expiry waits while the earlier one cannot leave
    assign fire    = (r_state == S_EVAL) && r_alloc[r_idx] && r_run[r_idx] && alu_res.expired;
    assign blocked = fire && r_pend_v && !out_free;
    assign advance = !blocked;

    // keep reading the current slot while blocked, else the next one
    assign rd_addr = ((r_state == S_EVAL) && advance) ? SLOT_W'(r_idx + 1'b1) : r_idx;

    // operand select for the shared arithmetic unit
    always_comb begin
        if (r_state == S_EVAL) begin
            alu_op.add_a = per_rd;
            alu_op.base  = dl_rd;
        end else begin
            alu_op.add_a = r_req.duration;
            alu_op.base  = r_req.now_ms;
        end
        alu_op.now = r_req.now_ms;
    end

    stb_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    stb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_SPAN)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (alu_res.sum),
        .i_raddr (rd_addr),
        .o_rdata (dl_rd)
    );

    stb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_SPAN)
    ) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (r_req.slot),
        .i_wdata (r_req.duration),
        .i_raddr (rd_addr),
        .o_rdata (per_rd)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_alloc     = r_alloc;
        n_per_mark  = r_per_mark;
        n_run       = r_run;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_out       = r_out;
        out_load    = 1'b0;
        dl_we       = 1'b0;
        dl_waddr    = r_idx;
        per_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req   = i_in;
                    n_state = (i_in.cmd == CMD_POLL) ? S_EVAL : S_EXEC;
                end
            end

            S_EVAL: begin
                if (advance) begin
                    if (fire) begin
                        if (r_per_mark[r_idx]) begin
                            dl_we = 1'b1;
                        end else begin
                            n_run[r_idx] = 1'b0;
                        end
                        if (r_pend_v) begin
                            out_load = 1'b1;
                            n_out    = '{status: ST_OK, slot_out: r_pend_slot,
                                         fired: 1'b1, last: 1'b0};
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = r_idx;
                    end
                    if (r_idx == SLOT_W'(SLOT_CNT - 1)) begin
                        n_idx   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = SLOT_W'(r_idx + 1'b1);
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{status: ST_OK, slot_out: r_pend_slot,
                                  fired: 1'b1, last: 1'b1};
                    end else begin
                        n_out = '{status: ST_OK, slot_out: '0, fired: 1'b0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    n_out    = '{status: ST_OK, slot_out: '0, fired: 1'b0, last: 1'b1};
                    unique case (r_req.cmd)
                        CMD_CREATE: begin
                            if (free_found) begin
                                n_alloc[free_idx]    = 1'b1;
                                n_per_mark[free_idx] = r_req.periodic;
                                n_run[free_idx]      = 1'b0;
                                n_out.slot_out       = free_idx;
                            end else begin
                                n_out.status = ST_NO_SLOT;
                            end
                        end
                        CMD_START: begin
                            if (!slot_ok || (r_req.duration == '0)) begin
                                n_out.status = ST_BAD_PARAM;
                            end else begin
                                dl_we              = 1'b1;
                                dl_waddr           = r_req.slot;
                                per_we             = 1'b1;
                                n_run[r_req.slot]  = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            if (!slot_ok) begin
                                n_out.status = ST_BAD_PARAM;
                            end else begin
                                n_run[r_req.slot] = 1'b0;
                            end
                        end
                        CMD_POLL: begin
                            n_out.status = ST_OK;
                        end
                        default: begin
                            n_out.status = ST_BAD_PARAM;
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_alloc     <= '0;
            r_per_mark  <= '0;
            r_run       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_alloc     <= n_alloc;
            r_per_mark  <= n_per_mark;
            r_run       <= n_run;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `STB_ASSERT_HOLDS(a_run_needs_alloc, i_clk, i_rst_n, 1'b1, (r_run & ~r_alloc) == '0, "running slot is not allocated")
    `STB_ASSERT_NEXT(a_blocked_holds_scan, i_clk, i_rst_n, blocked, (r_state == S_EVAL) && (r_idx == $past(r_idx)), "scan moved while blocked")
    `STB_ASSERT_NEXT(a_oneshot_stops, i_clk, i_rst_n, advance && fire && !r_per_mark[r_idx], !r_run[$past(r_idx)], "one-shot slot still running after fire")
    `STB_ASSERT_NEXT(a_flush_gives_last, i_clk, i_rst_n, (r_state == S_FLUSH) && out_free, r_out_valid && r_out.last && (r_state == S_IDLE), "poll ended without a last result")

endmodule
